>>> hdl/aes_pkg.sv
// shared types, constants and byte functions for the aes mode engine
package aes_pkg;

	localparam int RkDepth = 60;
	localparam int RkAw    = 6;

	localparam logic [2:0] MODE_ECB_ENC = 3'd0;
	localparam logic [2:0] MODE_ECB_DEC = 3'd1;
	localparam logic [2:0] MODE_CBC_ENC = 3'd2;
	localparam logic [2:0] MODE_CBC_DEC = 3'd3;
	localparam logic [2:0] MODE_CFB_ENC = 3'd4;
	localparam logic [2:0] MODE_CFB_DEC = 3'd5;

	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_MODE     = 3'd1;
	localparam logic [2:0] REG_KEY0     = 3'd2;
	localparam logic [2:0] REG_KEY1     = 3'd3;
	localparam logic [2:0] REG_KEY2     = 3'd4;
	localparam logic [2:0] REG_KEY3     = 3'd5;
	localparam logic [2:0] REG_IV_HI    = 3'd6;
	localparam logic [2:0] REG_IV_LO    = 3'd7;

	typedef logic [127:0] block_t;

	// round unit control
	typedef struct packed {
		logic decrypt;
		logic first;
		logic last;
	} rnd_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	function automatic logic [7:0] xt(input logic [7:0] b);
		xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// inverse sbox by searching the forward table
	function automatic logic [7:0] inv_sub_byte(input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (SBOX[i] == b) r = 8'(i);
		end
		inv_sub_byte = r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

>>> hdl/aes_ram.sv
// generic single port write, single read ram with registered read
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 60,
	parameter int Aw    = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [Aw-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic [Aw-1:0]    raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/aes_round.sv
// one aes round on a 128-bit state, forward or inverse
module aes_round (
	input  aes_pkg::block_t   state,
	input  aes_pkg::block_t   rkey,
	input  aes_pkg::rnd_ctl_t ctl,
	output aes_pkg::block_t   next
);
	logic [7:0] s   [16];
	logic [7:0] sub [16];
	logic [7:0] sh  [16];
	logic [7:0] mc  [16];
	logic [7:0] ak  [16];
	logic [7:0] a0, a1, a2, a3;

	// forward: sub, shift, mix, key. inverse: shift, sub, key, mix
	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = state[127-8*i -: 8];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (ctl.decrypt) sh[4*c+r] = s[4*((c+4-r)%4)+r];
				else sh[4*c+r] = aes_pkg::SBOX[s[4*((c+r)%4)+r]];
			end
		end
		for (int i = 0; i < 16; i++) begin
			sub[i] = ctl.decrypt ? aes_pkg::inv_sub_byte(sh[i]) : sh[i];
			ak[i]  = sub[i] ^ rkey[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (ctl.decrypt) begin
					a0 = ak[4*c+r];
					a1 = ak[4*c+(r+1)%4];
					a2 = ak[4*c+(r+2)%4];
					a3 = ak[4*c+(r+3)%4];
				end else begin
					a0 = sub[4*c+r];
					a1 = sub[4*c+(r+1)%4];
					a2 = sub[4*c+(r+2)%4];
					a3 = sub[4*c+(r+3)%4];
				end
				if (ctl.decrypt)
					// 0e 0b 0d 09
					mc[4*c+r] = (aes_pkg::xt(aes_pkg::xt(aes_pkg::xt(a0))) ^ aes_pkg::xt(aes_pkg::xt(a0)) ^ aes_pkg::xt(a0))
						^ (aes_pkg::xt(aes_pkg::xt(aes_pkg::xt(a1))) ^ aes_pkg::xt(a1) ^ a1)
						^ (aes_pkg::xt(aes_pkg::xt(aes_pkg::xt(a2))) ^ aes_pkg::xt(aes_pkg::xt(a2)) ^ a2)
						^ (aes_pkg::xt(aes_pkg::xt(aes_pkg::xt(a3))) ^ a3);
				else
					mc[4*c+r] = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (ctl.first) next[127-8*i -: 8] = s[i] ^ rkey[127-8*i -: 8];
			else if (ctl.last) next[127-8*i -: 8] = ak[i];
			else if (ctl.decrypt) next[127-8*i -: 8] = mc[i];
			else next[127-8*i -: 8] = mc[i] ^ rkey[127-8*i -: 8];
		end
	end
endmodule

>>> hdl/aes_block_cipher_modes_core.sv
// aes ecb/cbc/cfb engine top level with round sequencer and key schedule
// Usage: configuration registers are written through cfg_we/cfg_index/
// cfg_data while the engine is idle. Requests enter on in_valid/in_ready
// with data_high, data_low and first_block; results leave on
// out_valid/out_ready as result_high and result_low.
// One request is worked at a time. The shared round unit does one round
// at a time: it streams the four round key words out of the 32-bit key
// ram (registered read), then applies the round. After a key or key size
// write, and after reset, the next request first runs the key expansion,
// one word per cycle, which writes 4*(Nr+1) words (44, 52 or 60 for
// 128/192/256-bit keys) into the key ram.
// A finished result sits in the output register until taken; the next
// request is accepted in the same cycle the result is taken, or after,
// so a new request never starts before the last result is taken.
// When the receiver stalls, the engine holds the result and stays busy.
// Reset clears the registers, mode, chaining block and schedule flag;
// the key ram content is not cleared and is always rebuilt before use.
module aes_block_cipher_modes_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	input  logic        first_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KEXP = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [1:0]   key_size_q;
	logic [2:0]   mode_q;
	logic [63:0]  key_q [4];
	logic [127:0] iv_q, chain_q, din_q, blk_q;
	logic         sched_q;
	logic [3:0]   rnd_q;
	logic [5:0]   kidx_q;
	logic [2:0]   kpos_q;
	logic [31:0]  w_q [8];
	logic [7:0]   rc_q;
	logic [2:0]   ph_q;
	logic [3:0]   nk, nr;
	logic [2:0]   nk_m1;
	logic [5:0]   total;
	logic         dec_op, kdec, key_wr;
	logic [31:0]  kt, knew;
	logic [3:0]   rk_rnd;
	logic [5:0]   raddr;
	logic [31:0]  rdata;
	logic [31:0]  rk_q [3];
	aes_pkg::block_t   rnd_out;
	aes_pkg::rnd_ctl_t ctl;
	logic [127:0] src;
	logic [127:0] res_q;

	assign nk    = (key_size_q == 2'd0) ? 4'd4 : (key_size_q == 2'd1) ? 4'd6 : 4'd8;
	assign nr    = nk + 4'd6;
	assign nk_m1 = 3'(nk - 4'd1);
	assign total = 6'(({2'b0, nk} + 6'd7) << 2);
	assign dec_op = (mode_q == aes_pkg::MODE_ECB_DEC) || (mode_q == aes_pkg::MODE_CBC_DEC);
	assign key_wr = cfg_we && (cfg_index == aes_pkg::REG_KEY_SIZE
		|| cfg_index == aes_pkg::REG_KEY0 || cfg_index == aes_pkg::REG_KEY1
		|| cfg_index == aes_pkg::REG_KEY2 || cfg_index == aes_pkg::REG_KEY3);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			mode_q <= '0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			iv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aes_pkg::REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				aes_pkg::REG_MODE:     mode_q <= cfg_data[2:0];
				aes_pkg::REG_KEY0:     key_q[0] <= cfg_data;
				aes_pkg::REG_KEY1:     key_q[1] <= cfg_data;
				aes_pkg::REG_KEY2:     key_q[2] <= cfg_data;
				aes_pkg::REG_KEY3:     key_q[3] <= cfg_data;
				aes_pkg::REG_IV_HI:    iv_q[127:64] <= cfg_data;
				aes_pkg::REG_IV_LO:    iv_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	// key expansion word: window w_q holds the last nk words, kpos_q is the word index mod nk
	always_comb begin
		kt = w_q[nk_m1];
		kdec = (kidx_q < 6'(nk));
		if (kdec) knew = kidx_q[0] ? key_q[kidx_q[2:1]][31:0] : key_q[kidx_q[2:1]][63:32];
		else if (kpos_q == 3'd0)
			knew = w_q[0] ^ aes_pkg::sub_word({kt[23:0], kt[31:24]}) ^ {rc_q, 24'h0};
		else if (nk == 4'd8 && kpos_q == 3'd4) knew = w_q[0] ^ aes_pkg::sub_word(kt);
		else knew = w_q[0] ^ kt;
	end

	aes_ram #(.Width(32), .Depth(aes_pkg::RkDepth), .Aw(aes_pkg::RkAw)) u_rk (
		.clk(clk), .we(state_q == ST_KEXP), .waddr(kidx_q), .wdata(knew),
		.raddr(raddr), .rdata(rdata));

	// round key address: words of round rnd_q (round nr - rnd_q when decrypting) streamed by ph_q
	assign rk_rnd = dec_op ? (nr - rnd_q) : rnd_q;
	assign raddr = 6'({rk_rnd, 2'b00} + {4'b0, ph_q[1:0]});

	assign ctl.decrypt = dec_op;
	assign ctl.first   = (rnd_q == 4'd0);
	assign ctl.last    = (rnd_q == nr);
	// last key word comes straight from the ram read register
	assign src = {rk_q[0], rk_q[1], rk_q[2], rdata};

	aes_round u_round (.state(blk_q), .rkey(src), .ctl(ctl), .next(rnd_out));

	assign in_ready  = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready);
	assign out_valid = (state_q == ST_OUT);

	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sched_q <= 1'b0;
			chain_q <= '0;
			din_q <= '0;
			blk_q <= '0;
			res_q <= '0;
			rnd_q <= '0;
			kidx_q <= '0;
			kpos_q <= '0;
			ph_q <= '0;
			rc_q <= 8'h01;
			for (int i = 0; i < 8; i++) w_q[i] <= '0;
			for (int i = 0; i < 3; i++) rk_q[i] <= '0;
		end else begin
			// schedule flag: cleared by a key write, set when expansion ends
			if (key_wr)
				sched_q <= 1'b0;
			else if (state_q == ST_KEXP && kidx_q == total - 6'd1)
				sched_q <= 1'b1;
			unique case (state_q) inside
				ST_IDLE, ST_OUT: begin
					if (in_valid && in_ready) begin
						din_q <= {data_high, data_low};
						if (first_block) chain_q <= iv_q;
						kidx_q <= '0;
						kpos_q <= '0;
						rc_q <= 8'h01;
						ph_q <= '0;
						rnd_q <= '0;
						state_q <= sched_q ? ST_PREP : ST_KEXP;
					end else if (state_q == ST_OUT && out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_KEXP: begin
					for (int i = 0; i < 8; i++)
						w_q[i] <= (3'(i) == nk_m1) ? knew : w_q[(i + 1) % 8];
					if (!kdec && kpos_q == 3'd0) rc_q <= aes_pkg::xt(rc_q);
					kpos_q <= (kpos_q == nk_m1) ? 3'd0 : kpos_q + 3'd1;
					kidx_q <= kidx_q + 6'd1;
					if (kidx_q == total - 6'd1) state_q <= ST_PREP;
				end
				ST_PREP: begin
					// pick cipher input, key word 0 is fetched this cycle
					unique case (mode_q) inside
						aes_pkg::MODE_CBC_ENC: blk_q <= din_q ^ chain_q;
						aes_pkg::MODE_CFB_ENC, aes_pkg::MODE_CFB_DEC: blk_q <= chain_q;
						default: blk_q <= din_q;
					endcase
					ph_q <= 3'd1;
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (ph_q == 3'd4) begin
						// words 0 to 2 held, word 3 on rdata: run round
						blk_q <= rnd_out;
						ph_q <= 3'd0;
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == nr) begin
							state_q <= ST_OUT;
							unique case (mode_q)
								aes_pkg::MODE_CBC_ENC: begin
									res_q <= rnd_out; chain_q <= rnd_out;
								end
								aes_pkg::MODE_CBC_DEC: begin
									res_q <= rnd_out ^ chain_q; chain_q <= din_q;
								end
								aes_pkg::MODE_CFB_ENC: begin
									res_q <= rnd_out ^ din_q; chain_q <= rnd_out ^ din_q;
								end
								aes_pkg::MODE_CFB_DEC: begin
									res_q <= rnd_out ^ din_q; chain_q <= din_q;
								end
								default: res_q <= rnd_out;
							endcase
						end
					end else begin
						// rdata arrives in the cycle after its address
						if (ph_q != 3'd0) rk_q[2'(ph_q[1:0] - 2'd1)] <= rdata;
						ph_q <= ph_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/aes_core_checker.sv
// port-level checks for the aes mode engine, bound to the top level
module aes_core_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_high
);
	// no new request while a result is pending unless it is taken
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("ready while result stalled");
	// result stays valid, with its high half stable, while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_high))
		else $error("result dropped");
	// accepted request never gives a result next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
	// engine busy after accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready while busy");
endmodule

bind aes_block_cipher_modes_core aes_core_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result_high(result_high));

>>> tb/sv/aes_mode_checker.sv
// request/result monitor with a cycle-free aes mode predictor and result compare
`timescale 1ns / 1ps

module aes_mode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	input  logic        first_block,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] result_high,
	input  logic [63:0] result_low,
	output int          fail_count,
	output int          blocks_left
);

	localparam logic [1:0] KEY_SIZE_256 = 2'd2;

	// shadow copy of the registers and engine state
	logic [1:0]   key_size_q;
	logic [2:0]   mode_q;
	logic [63:0]  key_q [4];
	logic [63:0]  iv_hi_q;
	logic [63:0]  iv_lo_q;
	logic [31:0]  sched [60];
	bit           sched_ok;
	logic [127:0] chain_q;
	logic [7:0]   inv_tab [256];
	logic [127:0] expected_blocks [$];

	initial begin
		for (int i = 0; i < 256; i++) inv_tab[aes_pkg::SBOX[i]] = 8'(i);
	end

	function automatic logic [7:0] dbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = dbl(a);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic int key_words();
		return 4 + 2 * ((key_size_q > KEY_SIZE_256) ? 2 : int'(key_size_q));
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
			aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
	endfunction

	// round key expansion into the shadow store
	function automatic void build_round_keys();
		int nk;
		logic [31:0] t;
		logic [7:0] rc;
		nk = key_words();
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
		for (int i = nk; i < 4 * (nk + 7); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = dbl(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = subst_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_ok = 1'b1;
	endfunction

	// one block through the forward or inverse cipher
	function automatic logic [127:0] run_cipher(input logic [127:0] blk, input bit decrypt);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a [4];
		logic [127:0] res;
		int nr;
		int rnd;
		nr = key_words() + 6;
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
		for (int step = 0; step <= nr; step++) begin
			rnd = decrypt ? nr - step : step;
			if (step != 0) begin
				if (!decrypt)
					for (int i = 0; i < 16; i++) s[i] = aes_pkg::SBOX[s[i]];
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						t[4 * c + r] = s[4 * (decrypt ? ((c + 4 - r) & 3) : ((c + r) & 3)) + r];
				s = t;
				if (decrypt)
					for (int i = 0; i < 16; i++) s[i] = inv_tab[s[i]];
				if (!decrypt && rnd != nr) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) a[r] = s[4 * c + r];
						for (int r = 0; r < 4; r++)
							s[4 * c + r] = dbl(a[r]) ^ dbl(a[(r + 1) & 3]) ^ a[(r + 1) & 3]
								^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
					end
				end
			end
			// add round key
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4 * c + r] ^= sched[(4 * rnd + c) % 60][31 - 8 * r -: 8];
			if (decrypt && step != 0 && rnd != 0) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) a[r] = s[4 * c + r];
					for (int r = 0; r < 4; r++)
						s[4 * c + r] = gf_mul(a[r], 8'h0e) ^ gf_mul(a[(r + 1) & 3], 8'h0b)
							^ gf_mul(a[(r + 2) & 3], 8'h0d) ^ gf_mul(a[(r + 3) & 3], 8'h09);
				end
			end
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	// expected output block for one request, updates the chaining block in the chained modes
	function automatic logic [127:0] predict_block(input logic [127:0] d, input logic first);
		logic [127:0] r;
		if (!sched_ok) build_round_keys();
		if (first) chain_q = {iv_hi_q, iv_lo_q};
		case (mode_q) inside
			aes_pkg::MODE_ECB_DEC: r = run_cipher(d, 1'b1);
			aes_pkg::MODE_CBC_ENC: begin
				r = run_cipher(d ^ chain_q, 1'b0);
				chain_q = r;
			end
			aes_pkg::MODE_CBC_DEC: begin
				r = run_cipher(d, 1'b1) ^ chain_q;
				chain_q = d;
			end
			aes_pkg::MODE_CFB_ENC, aes_pkg::MODE_CFB_DEC: begin
				r = d ^ run_cipher(chain_q, 1'b0);
				chain_q = (mode_q == aes_pkg::MODE_CFB_ENC) ? r : d;
			end
			default: r = run_cipher(d, 1'b0);
		endcase
		return r;
	endfunction

	function automatic void report(input string what, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
	endfunction

	// register writes, request prediction and result compare
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			key_size_q = '0;
			mode_q     = '0;
			for (int i = 0; i < 4; i++) key_q[i] = '0;
			iv_hi_q    = '0;
			iv_lo_q    = '0;
			sched_ok   = 1'b0;
			chain_q    = '0;
			fail_count = 0;
			expected_blocks.delete();
			blocks_left = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index) inside
					aes_pkg::REG_KEY_SIZE: begin
						key_size_q = cfg_data[1:0];
						sched_ok = 1'b0;
					end
					aes_pkg::REG_MODE: mode_q = cfg_data[2:0];
					aes_pkg::REG_KEY0, aes_pkg::REG_KEY1, aes_pkg::REG_KEY2,
					aes_pkg::REG_KEY3: begin
						key_q[2'(cfg_index - aes_pkg::REG_KEY0)] = cfg_data;
						sched_ok = 1'b0;
					end
					aes_pkg::REG_IV_HI: iv_hi_q = cfg_data;
					aes_pkg::REG_IV_LO: iv_lo_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_blocks.push_back(predict_block({data_high, data_low}, first_block));
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h %h", result_high, result_low);
				end else begin
					want = expected_blocks.pop_front();
					if (result_high !== want[127:64])
						report("result_high", want[127:64], result_high);
					if (result_low !== want[63:0])
						report("result_low", want[63:0], result_low);
				end
			end
			blocks_left = expected_blocks.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// top of the aes mode engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] MODE_RSVD6   = 3'd6;
	localparam logic [2:0] MODE_RSVD7   = 3'd7;
	localparam logic [1:0] KEY_SIZE_RSVD = 2'd3;
	localparam int REQ_TARGET  = 1700;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] data_high;
	logic [63:0] data_low;
	logic        first_block;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	int          fail_count;
	int          blocks_left;
	int          reqs_sent;
	int          results_taken;
	int          idle_cycles;
	int          phases;
	bit          long_hold_done;

	aes_block_cipher_modes_core dut (.*);

	aes_mode_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// handshake counters and stall watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			reqs_sent <= 0;
			results_taken <= 0;
			idle_cycles <= 0;
		end else begin
			if (in_valid && in_ready) reqs_sent <= reqs_sent + 1;
			if (out_valid && out_ready) results_taken <= results_taken + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without progress", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic bit quiet_stretch();
		return reqs_sent >= 600 && reqs_sent < 900;
	endfunction

	// result side: random back-pressure plus one long hold-off
	initial begin
		int hold;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_taken >= 100 && in_valid) begin
				long_hold_done = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_ready = 1'b0;
			end else begin
				out_ready = quiet_stretch() || ($urandom_range(99) >= 13);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
	endtask

	// one request, held until accepted; leaves valid high at the next falling edge
	task automatic send_req(input logic [63:0] hi, input logic [63:0] lo, input logic first);
		int gap;
		gap = (!quiet_stretch() && $urandom_range(99) < 13) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_high   = hi;
		data_low    = lo;
		first_block = first;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// sender pause until every result is back
	task automatic drain();
		in_valid = 1'b0;
		while (results_taken != reqs_sent) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int msgs;
		int len;
		bit carry;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aes_pkg::REG_KEY_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		data_high = '0;
		data_low = '0;
		first_block = 1'b0;
		phases = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// straight out of reset: all-zero key, zero chaining block
		send_req('0, '0, 1'b0);
		drain();

		// directed: known key, every mode code and key size code, extreme data
		write_reg(aes_pkg::REG_KEY0, 64'h0001020304050607);
		write_reg(aes_pkg::REG_KEY1, 64'h08090a0b0c0d0e0f);
		write_reg(aes_pkg::REG_KEY2, 64'h1011121314151617);
		write_reg(aes_pkg::REG_KEY3, 64'h18191a1b1c1d1e1f);
		write_reg(aes_pkg::REG_IV_HI, '1);
		write_reg(aes_pkg::REG_IV_LO, '1);
		cfg_we = 1'b0;
		for (int m = 0; m <= int'(MODE_RSVD7); m++) begin
			write_reg(aes_pkg::REG_KEY_SIZE, 64'(m % 4));
			write_reg(aes_pkg::REG_MODE, 64'(m));
			cfg_we = 1'b0;
			send_req(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
			send_req('1, '1, 1'b0);
			send_req('0, '0, 1'b0);
			drain();
		end

		// random phases of messages under changing settings
		while (reqs_sent < REQ_TARGET) begin
			phases++;
			if (phases == 1 || $urandom_range(2) == 0) begin
				write_reg(aes_pkg::REG_KEY_SIZE, (phases % 7 == 0) ? 64'(KEY_SIZE_RSVD) :
					64'($urandom_range(0, 2)));
				write_reg(aes_pkg::REG_KEY0, rand_word());
				write_reg(aes_pkg::REG_KEY1, rand_word());
				write_reg(aes_pkg::REG_KEY2, rand_word());
				write_reg(aes_pkg::REG_KEY3, rand_word());
			end
			if ($urandom_range(1)) begin
				write_reg(aes_pkg::REG_IV_HI, rand_word());
				write_reg(aes_pkg::REG_IV_LO, rand_word());
			end
			write_reg(aes_pkg::REG_MODE, ($urandom_range(9) == 0) ?
				64'($urandom_range(MODE_RSVD6, MODE_RSVD7)) :
				64'($urandom_range(aes_pkg::MODE_ECB_ENC, aes_pkg::MODE_CFB_DEC))
					| ({$urandom, $urandom} & ~64'h7));
			cfg_we = 1'b0;
			// a mode change in mid-message keeps the chaining block
			carry = (phases > 1) && ($urandom_range(99) < 15);
			msgs = $urandom_range(1, 3);
			for (int k = 0; k < msgs; k++) begin
				len = $urandom_range(1, 12);
				for (int j = 0; j < len; j++) begin
					send_req(rand_word(), rand_word(),
						($urandom_range(99) < 8) ? 1'($urandom) : (j == 0 && !(carry && k == 0)));
				end
			end
			drain();
		end

		drain();
		$display("covered %0d requests over %0d random phases plus directed mode/key-size sweep",
			reqs_sent, phases);
		$display("results checked %0d, long result hold-off %0s", results_taken,
			long_hold_done ? "applied" : "not reached");
		if (fail_count == 0 && blocks_left == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_round.sv
hdl/aes_block_cipher_modes_core.sv
hdl/aes_core_checker.sv
tb/sv/aes_mode_checker.sv
tb/sv/tb_top.sv
